/* sv/sfm_pkg.sv */
`timescale 1ns / 1ps

package sfm_pkg;

	// Default sizing of the finder.
	localparam int unsigned PATTERN_MAX_DEF  = 16;
	localparam int unsigned OFFSET_WIDTH_DEF = 16;

	// Pattern storage is always sixteen bytes wide, as two 64-bit registers.
	localparam int unsigned PATTERN_BYTES    = 16;
	localparam int unsigned CFG_DATA_WIDTH   = 64;
	localparam int unsigned CFG_INDEX_WIDTH  = 2;
	localparam int unsigned CFG_LEN_WIDTH    = 5;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LEN  = 2'd2;

	// Width of the result fields on the output word.
	localparam int unsigned RESULT_OFFSET_WIDTH = 16;

	// Pattern bytes, byte 0 in the lowest slot.
	typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

	// Control broadcast to every window cell.
	typedef struct packed {
		logic advance;   // a text byte is taken this cycle
		logic clear;     // that byte ends the text, so the window empties
	} cell_ctrl_t;

endpackage

/* sv/sfm_cell.sv */
`timescale 1ns / 1ps

// One cell of the window chain. It compares the byte handed in from its
// neighbour with the pattern byte that lines up with its place in the window,
// and on every accepted word it takes that byte into its own register (zero at text end).
module sfm_cell #(
	parameter int unsigned INDEX     = 0,
	parameter int unsigned LEN_WIDTH = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfm_pkg::cell_ctrl_t   ctrl,
	input  logic [7:0]            byte_in,
	input  sfm_pkg::pattern_t     pattern,
	input  logic [LEN_WIDTH-1:0]  len,
	output logic [7:0]            byte_out,
	output logic                  eq
);

	localparam int unsigned SEL_WIDTH = ((LEN_WIDTH > 4) ? LEN_WIDTH : 4) + 1;

	logic [7:0]           byte_q;
	logic [SEL_WIDTH-1:0] sel;
	logic                 in_use;

	// The cell at window place INDEX meets pattern byte len-1-INDEX.
	always_comb begin
		in_use = SEL_WIDTH'(INDEX) < SEL_WIDTH'(len);
		sel    = SEL_WIDTH'(len) - SEL_WIDTH'(INDEX) - SEL_WIDTH'(1);
		eq     = !in_use || (byte_in == pattern[sel[3:0]]);
	end

	// Window register, emptied when the text ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.advance) begin
			byte_q <= ctrl.clear ? 8'd0 : byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

/* sv/substring_first_match_finder.sv */
`timescale 1ns / 1ps

// Channel     Dir  Width  Contents (lowest bit first)
// s_axis      in   8      text_byte
// m_axis      out  24     match_found, match_offset[15:0], text_too_long, zero fill
// cfg         in   64     index 0 pattern low bytes, 1 pattern high bytes, 2 length
//
// The whole window is compared in parallel by a chain of PATTERN_MAX cells,
// so one word is accepted in every cycle while the input is not held back.
// A result word is registered and appears in the cycle after the terminating zero byte.
// A stalled result only holds the input back when the output register is full
// and not being taken in the same cycle.
// Reset clears the window, the position counter, the match record and the
// pattern registers; no clearing pass is needed.
module substring_first_match_finder #(
	parameter int unsigned PATTERN_MAX  = sfm_pkg::PATTERN_MAX_DEF,
	parameter int unsigned OFFSET_WIDTH = sfm_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Text input.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,   // text_byte
	// Result output.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// match_found, match_offset[15:0], text_too_long, zero fill to 24 bits
	output logic [23:0]                         m_axis_tdata,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [sfm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [sfm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int unsigned LEN_WIDTH = $clog2(PATTERN_MAX + 1);
	localparam int unsigned RW        = sfm_pkg::RESULT_OFFSET_WIDTH;

	logic [sfm_pkg::CFG_DATA_WIDTH-1:0] pat_lo_q;
	logic [sfm_pkg::CFG_DATA_WIDTH-1:0] pat_hi_q;
	logic [sfm_pkg::CFG_LEN_WIDTH-1:0]  pat_len_q;

	sfm_pkg::pattern_t      pattern;
	logic [LEN_WIDTH-1:0]   len_cap;
	logic [LEN_WIDTH-1:0]   len_eff;

	logic [OFFSET_WIDTH:0]   pos_q;
	logic                    found_q;
	logic [OFFSET_WIDTH-1:0] first_q;

	logic                    out_valid_q;
	logic                    out_found_q;
	logic [RW-1:0]           out_offset_q;
	logic                    out_long_q;

	logic                    in_acc;
	logic                    term;
	logic                    below_limit;
	logic                    at_or_below_limit;
	logic                    hit;
	logic [OFFSET_WIDTH-1:0] hit_offset;
	logic [OFFSET_WIDTH+RW-1:0] first_ext;

	sfm_pkg::cell_ctrl_t     ctrl;
	logic [7:0]              win [PATTERN_MAX+1];
	logic [PATTERN_MAX-1:0]  eq;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfm_pkg::REG_PATTERN_LOW:  pat_lo_q  <= cfg_data;
				sfm_pkg::REG_PATTERN_HIGH: pat_hi_q  <= cfg_data;
				sfm_pkg::REG_PATTERN_LEN:
					pat_len_q <= cfg_data[sfm_pkg::CFG_LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign pattern = {pat_hi_q, pat_lo_q};

	// Used length: capped at the cell count and cut at the first zero byte.
	always_comb begin
		if (int'(pat_len_q) > int'(PATTERN_MAX)) begin
			len_cap = LEN_WIDTH'(PATTERN_MAX);
		end else begin
			len_cap = LEN_WIDTH'(pat_len_q);
		end
		len_eff = len_cap;
		for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
			if ((k < int'(len_cap)) && (pattern[k] == 8'd0)) begin
				len_eff = LEN_WIDTH'(k);
			end
		end
	end

	// Handshake: the output register frees itself when taken.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign term          = in_acc && (s_axis_tdata == 8'd0);

	assign ctrl.advance = in_acc;
	assign ctrl.clear   = term;

	// Window chain: place 0 is the incoming byte, cell k stores it for k+1.
	assign win[0] = s_axis_tdata;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		sfm_cell #(
			.INDEX     (k),
			.LEN_WIDTH (LEN_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.byte_in  (win[k]),
			.pattern  (pattern),
			.len      (len_eff),
			.byte_out (win[k+1]),
			.eq       (eq[k])
		);
	end

	// Match decision for the current byte.
	always_comb begin
		below_limit       = !pos_q[OFFSET_WIDTH];
		at_or_below_limit = below_limit || (pos_q[OFFSET_WIDTH-1:0] == '0);
		hit = (len_eff != '0) && (&eq) && !found_q && below_limit
			&& (s_axis_tdata != 8'd0);
		hit_offset = pos_q[OFFSET_WIDTH-1:0] + OFFSET_WIDTH'(1)
			- OFFSET_WIDTH'(len_eff);
		first_ext  = {{RW{1'b0}}, first_q};
	end

	// Per-text state: position counter and first match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
			first_q <= '0;
		end else if (term) begin
			pos_q   <= '0;
			found_q <= 1'b0;
			first_q <= '0;
		end else if (in_acc) begin
			if (at_or_below_limit) begin
				pos_q <= pos_q + (OFFSET_WIDTH+1)'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
				first_q <= hit_offset;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (term) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, loaded on the terminating byte.
	always_ff @(posedge clk) begin
		if (term) begin
			out_long_q <= !at_or_below_limit;
			if (len_eff == '0) begin
				out_found_q  <= 1'b1;
				out_offset_q <= '0;
			end else begin
				out_found_q  <= found_q;
				out_offset_q <= found_q ? first_ext[RW-1:0] : '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_long_q, out_offset_q, out_found_q};

	// The terminating byte empties the whole chain down to its last cell and clears the text state.
	a_chain_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		term |=> (win[PATTERN_MAX] == 8'd0) && (pos_q == '0) && !found_q)
		else $error("window or text state not cleared after end of text");

	// A match is only ever recorded while the position is inside the range.
	a_record_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(!pos_q[OFFSET_WIDTH]))
		else $error("match recorded beyond the offset range");

	// A result with no match carries a zero offset.
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_offset_q == '0))
		else $error("offset set on a result without a match");

	// The input waits only while an untaken result sits in the output register.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (out_valid_q && !m_axis_tready))
		else $error("input stalled without a pending result");

endmodule
